[rtl/qrm_pkg.sv]
// qrm_pkg: shared types and constants for the quadrant rotate matrix store
// field widths, operation codes, register indexes and the remap result struct
// no dependencies
package qrm_pkg;

  localparam int ROW_W            = 5;
  localparam int VAL_W            = 32;
  localparam int HALF_W           = 4;
  localparam int HALF_LIMIT       = (1 << HALF_W) - 1;
  localparam int DEF_MAX_HALF     = 15;
  localparam int DEF_ELEMENT_BITS = 32;
  localparam int DATA_W           = 32;
  localparam int PADDR_W          = 3;

  localparam logic [HALF_W-1:0] HALF_RESET = 4'd1;

  // register index in the apb map (byte address / 4)
  localparam logic REG_HALF_SIZE = 1'b0;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  // source position of a read plus the side-length check
  typedef struct packed {
    logic             in_range;
    logic [ROW_W-1:0] src_row;
    logic [ROW_W-1:0] src_col;
  } remap_t;

endpackage

[rtl/quadrant_rotate_matrix_store_core.sv]
// quadrant_rotate_matrix_store_core: top level of the quadrant rotate matrix store
// instantiates qrm_remap and qrm_mem, uses qrm_pkg
//
// usage:
//   input channel: an item is taken at a clock edge with start high and busy low.
//   busy is always low, so an item can be taken every cycle.
//   a write item (in_operation = OP_WRITE) stores in_element_value at
//   (in_row, in_column) as given; positions beyond side 2n+1 are dropped and
//   give no result.
//   a read item returns the element seen after each n-by-n corner quadrant is
//   turned clockwise; middle row and column are unchanged.
//   result channel: out_valid is high for one cycle with out_rotated_value and
//   out_out_of_range; the receiver cannot stall, so results are never held.
//   the result of a read shows in the cycle after the item is taken, from the
//   registered memory read; throughput is one item per cycle, set by the
//   single memory port that each item uses at most once.
//   out-of-range reads return zero with out_out_of_range set.
//   configuration: apb register 0 (byte address 0) holds half_size n, reset 1,
//   values above MAX_HALF act as MAX_HALF; write it only while idle.
//   reset: synchronous active-low rst_n clears control state; the element store
//   is not cleared, reading an unwritten element returns an unknown value.
module quadrant_rotate_matrix_store_core import qrm_pkg::*; #(
  parameter int MAX_HALF     = DEF_MAX_HALF,
  parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  // input channel
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_operation,
  input  logic [ROW_W-1:0]        in_row,
  input  logic [ROW_W-1:0]        in_column,
  input  logic signed [VAL_W-1:0] in_element_value,
  // result channel
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_rotated_value,
  output logic                    out_out_of_range
);

  // highest usable half size and the index width it needs
  localparam int EFF_HALF = (MAX_HALF < HALF_LIMIT) ? MAX_HALF : HALF_LIMIT;
  localparam int IDX_W    = $clog2(2 * EFF_HALF + 1);
  localparam int ADDR_W   = 2 * IDX_W;

  logic [HALF_W-1:0]       half_size_r;
  logic                    cfg_wr;
  logic                    accept;
  logic                    is_read;
  remap_t                  remap;
  logic [ADDR_W-1:0]       mem_addr;
  logic [ELEMENT_BITS-1:0] mem_wdata;
  logic [ELEMENT_BITS-1:0] mem_rdata;
  logic [VAL_W-1:0]        rd_value;
  logic                    out_valid_r;
  logic                    oor_r;

  // apb: always ready, one register in the word at byte address 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_HALF_SIZE);
  assign prdata = (paddr[2] == REG_HALF_SIZE) ? DATA_W'(half_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_size_r <= HALF_RESET;
    end else if (cfg_wr) begin
      half_size_r <= pwdata[HALF_W-1:0];
    end
  end

  // at most one memory access per item, so the block never holds items off
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_read = (op_t'(in_operation) == OP_READ);

  qrm_remap #(
    .MAX_HALF (MAX_HALF)
  ) u_remap (
    .half_size (half_size_r),
    .row       (in_row),
    .column    (in_column),
    .remap     (remap)
  );

  // writes go to the raw position, reads to the rotated source position
  always_comb begin
    if (is_read) begin
      mem_addr = {remap.src_row[IDX_W-1:0], remap.src_col[IDX_W-1:0]};
    end else begin
      mem_addr = {in_row[IDX_W-1:0], in_column[IDX_W-1:0]};
    end
  end

  // element width adaptation on the way in and out
  generate
    if (ELEMENT_BITS >= VAL_W) begin : g_wide
      assign mem_wdata = ELEMENT_BITS'(unsigned'(in_element_value));
      assign rd_value  = mem_rdata[VAL_W-1:0];
    end else begin : g_narrow
      assign mem_wdata = in_element_value[ELEMENT_BITS-1:0];
      assign rd_value  = VAL_W'(mem_rdata);
    end
  endgenerate

  qrm_mem #(
    .ADDR_W (ADDR_W),
    .WIDTH  (ELEMENT_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (accept && !is_read && remap.in_range),
    .rd_en   (accept && is_read && remap.in_range),
    .addr    (mem_addr),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

  // result strobe lines up with the registered memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept && is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_read) begin
      oor_r <= !remap.in_range;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_out_of_range  = oor_r;
  assign out_rotated_value = oor_r ? '0 : signed'(rd_value);

endmodule

[rtl/qrm_remap.sv]
// qrm_remap: maps a requested position to the stored position after the
// clockwise quadrant turns, and checks it against the matrix side
// depends on qrm_pkg
module qrm_remap import qrm_pkg::*; #(
  parameter int MAX_HALF = DEF_MAX_HALF
) (
  input  logic [HALF_W-1:0] half_size,
  input  logic [ROW_W-1:0]  row,
  input  logic [ROW_W-1:0]  column,
  output remap_t            remap
);

  // the register cannot express more than HALF_LIMIT anyway
  localparam int EFF_HALF = (MAX_HALF < HALF_LIMIT) ? MAX_HALF : HALF_LIMIT;
  localparam int CALC_W   = ROW_W + 1;

  logic [HALF_W-1:0] n;
  logic [CALC_W-1:0] n_w, side, row_w, col_w;
  logic [CALC_W-1:0] base_r, base_c, lr, lc, src_r, src_c;

  always_comb begin
    n      = (half_size > HALF_W'(EFF_HALF)) ? HALF_W'(EFF_HALF) : half_size;
    n_w    = CALC_W'(n);
    side   = (n_w << 1) + CALC_W'(1);
    row_w  = CALC_W'(row);
    col_w  = CALC_W'(column);
    base_r = (row_w < n_w) ? '0 : n_w + CALC_W'(1);
    base_c = (col_w < n_w) ? '0 : n_w + CALC_W'(1);
    lr     = row_w - base_r;
    lc     = col_w - base_c;
    // middle row and middle column stay put
    if ((row_w != n_w) && (col_w != n_w)) begin
      src_r = base_r + n_w - CALC_W'(1) - lc;
      src_c = base_c + lr;
    end else begin
      src_r = row_w;
      src_c = col_w;
    end
    remap.in_range = (row_w < side) && (col_w < side);
    remap.src_row  = src_r[ROW_W-1:0];
    remap.src_col  = src_c[ROW_W-1:0];
  end

endmodule

[rtl/qrm_mem.sv]
// qrm_mem: single-port synchronous element store with a registered read
// depends on qrm_pkg for the default WIDTH (DEF_ELEMENT_BITS)
module qrm_mem import qrm_pkg::*; #(
  parameter int ADDR_W = 10,
  parameter int WIDTH  = DEF_ELEMENT_BITS
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wr_data,
  output logic [WIDTH-1:0]  rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
